>>> design/bahs_pkg.sv
`timescale 1ns / 1ps

package bahs_pkg;

    // Window and pattern geometry
    localparam int WINDOW_LEN    = 10;
    localparam int PATTERN_BYTES = 11;
    localparam int NUM_SHIFTS    = 8;
    localparam int SHIFT_W       = 3;
    localparam int POS_W         = 16;
    localparam int DIST_W        = 7;
    localparam int THR_W         = 7;
    localparam int FILL_W        = $clog2(WINDOW_LEN + 1);
    localparam int WIN_W         = WINDOW_LEN * 8;
    localparam int PAT_W         = PATTERN_BYTES * 8;
    localparam int PAT_EXT_W     = (WINDOW_LEN + 1) * 8;
    localparam int SUM_W         = $clog2(WIN_W + 1);
    localparam int HALF_LEN      = WINDOW_LEN / 2;

    localparam logic [DIST_W-1:0] DIST_MAX        = {DIST_W{1'b1}};
    localparam logic [POS_W-1:0]  POS_MAX         = {POS_W{1'b1}};
    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 7'd20;

    // Register port
    localparam int UPPER_W  = 64;
    localparam int LOWER_W  = 24;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 64;
    localparam int RIDX_LSB = 3;

    typedef enum logic [1:0] {
        REG_PATTERN_UPPER   = 2'd0,
        REG_PATTERN_LOWER   = 2'd1,
        REG_MATCH_THRESHOLD = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [UPPER_W-1:0] pattern_upper;
        logic [LOWER_W-1:0] pattern_lower;
        logic [THR_W-1:0]   threshold;
    } cfg_t;

    // Per-window correlation outcome
    typedef struct packed {
        logic [NUM_SHIFTS-1:0]              mask;
        logic [NUM_SHIFTS-1:0][DIST_W-1:0]  distance;
        logic [POS_W-1:0]                   pos;
    } match_t;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int b = 0; b < 8; b++) begin
            n = n + {3'b000, v[b]};
        end
        return n;
    endfunction

endpackage

>>> design/bahs_regs.sv
`timescale 1ns / 1ps

module bahs_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bahs_pkg::PADDR_W-1:0]     paddr,
    input  logic [bahs_pkg::PDATA_W-1:0]     pwdata,
    output logic [bahs_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    output bahs_pkg::cfg_t                   cfg
);

    logic [bahs_pkg::UPPER_W-1:0] upper_reg;
    logic [bahs_pkg::LOWER_W-1:0] lower_reg;
    logic [bahs_pkg::THR_W-1:0]   thr_reg;
    bahs_pkg::reg_idx_t           idx;
    logic                         wr_en;

    assign pready = 1'b1;
    assign idx    = bahs_pkg::reg_idx_t'(paddr[bahs_pkg::PADDR_W-1:bahs_pkg::RIDX_LSB]);
    assign wr_en  = psel && penable && pwrite;

    // Register writes; unknown addresses are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg <= '0;
            lower_reg <= '0;
            thr_reg   <= bahs_pkg::THRESHOLD_RESET;
        end else if (wr_en) begin
            unique case (idx)
                bahs_pkg::REG_PATTERN_UPPER: begin
                    upper_reg <= pwdata[bahs_pkg::UPPER_W-1:0];
                end
                bahs_pkg::REG_PATTERN_LOWER: begin
                    lower_reg <= pwdata[bahs_pkg::LOWER_W-1:0];
                end
                bahs_pkg::REG_MATCH_THRESHOLD: begin
                    thr_reg <= pwdata[bahs_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read-back
    always_comb begin
        unique case (idx)
            bahs_pkg::REG_PATTERN_UPPER:
                prdata = bahs_pkg::PDATA_W'(upper_reg);
            bahs_pkg::REG_PATTERN_LOWER:
                prdata = bahs_pkg::PDATA_W'(lower_reg);
            bahs_pkg::REG_MATCH_THRESHOLD:
                prdata = bahs_pkg::PDATA_W'(thr_reg);
            default:
                prdata = '0;
        endcase
    end

    assign cfg.pattern_upper = upper_reg;
    assign cfg.pattern_lower = lower_reg;
    assign cfg.threshold     = thr_reg;

endmodule

>>> design/bahs_window.sv
`timescale 1ns / 1ps

module bahs_window (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_stream_byte,
    input  logic                           s_restart,
    input  logic                           advance,
    output logic [bahs_pkg::WIN_W-1:0]     window,
    output logic [bahs_pkg::POS_W-1:0]     position,
    output logic                           win_valid
);

    logic [bahs_pkg::WIN_W-1:0]  win_reg;
    logic [bahs_pkg::FILL_W-1:0] fill_reg, fill_next, fill_base;
    logic [bahs_pkg::POS_W-1:0]  pos_reg, pos_next, pos_base;
    logic                        valid_reg, valid_next;
    logic                        accept, full_now;

    assign s_ready = !valid_reg || advance;
    assign accept  = s_valid && s_ready;

    // Fill and position bookkeeping for the incoming beat
    always_comb begin
        fill_base = s_restart ? '0 : fill_reg;
        pos_base  = s_restart ? '0 : pos_reg;
        fill_next = fill_base;
        pos_next  = pos_base;
        full_now  = 1'b0;
        if (fill_base >= bahs_pkg::FILL_W'(bahs_pkg::WINDOW_LEN)) begin
            full_now = 1'b1;
            if (pos_base != bahs_pkg::POS_MAX) begin
                pos_next = pos_base + 1'b1;
            end
        end else begin
            fill_next = fill_base + 1'b1;
            if (fill_next == bahs_pkg::FILL_W'(bahs_pkg::WINDOW_LEN)) begin
                full_now = 1'b1;
                pos_next = '0;
            end
        end
    end

    // Window holds a full item only until the correlator hands it on
    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = full_now;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (accept) begin
                fill_reg <= fill_next;
                pos_reg  <= pos_next;
            end
        end
    end

    // Byte shift line, oldest byte at the top
    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg <= {win_reg[bahs_pkg::WIN_W-9:0], s_stream_byte};
        end
    end

    assign window    = win_reg;
    assign position  = pos_reg;
    assign win_valid = valid_reg;

endmodule

>>> design/bahs_corr.sv
`timescale 1ns / 1ps

module bahs_corr (
    input  logic [bahs_pkg::WIN_W-1:0] window,
    input  logic [bahs_pkg::POS_W-1:0] position,
    input  bahs_pkg::cfg_t             cfg,
    output bahs_pkg::match_t           match
);

    logic [bahs_pkg::PAT_W-1:0]     pat;
    logic [bahs_pkg::PAT_EXT_W-1:0] pat_ext;

    assign pat = {cfg.pattern_upper, cfg.pattern_lower};

    // Pattern bytes past the configured eleven read as zero
    generate
        if (bahs_pkg::PAT_EXT_W >= bahs_pkg::PAT_W) begin : g_pad
            assign pat_ext = bahs_pkg::PAT_EXT_W'(
                {pat, {(bahs_pkg::PAT_EXT_W - bahs_pkg::PAT_W + 1){1'b0}}} >> 1);
        end else begin : g_cut
            assign pat_ext = pat[bahs_pkg::PAT_W-1 -: bahs_pkg::PAT_EXT_W];
        end
    endgenerate

    // One distance lane per bit alignment
    genvar s;
    generate
        for (s = 0; s < bahs_pkg::NUM_SHIFTS; s++) begin : g_shift
            logic [bahs_pkg::WIN_W-1:0]  diff;
            logic [4:0]                  pair [bahs_pkg::HALF_LEN];
            logic [bahs_pkg::SUM_W-1:0]  sum;
            logic [bahs_pkg::DIST_W-1:0] dist_val;

            assign diff = pat_ext[bahs_pkg::PAT_EXT_W-1-s -: bahs_pkg::WIN_W] ^ window;

            // Byte pairs first, then the pair totals
            always_comb begin
                for (int i = 0; i < bahs_pkg::HALF_LEN; i++) begin
                    pair[i] = {1'b0, bahs_pkg::popcount8(
                                  diff[bahs_pkg::WIN_W-1-16*i -: 8])}
                            + {1'b0, bahs_pkg::popcount8(
                                  diff[bahs_pkg::WIN_W-9-16*i -: 8])};
                end
                sum = '0;
                for (int i = 0; i < bahs_pkg::HALF_LEN; i++) begin
                    sum = sum + bahs_pkg::SUM_W'(pair[i]);
                end
                if (bahs_pkg::WINDOW_LEN % 2 == 1) begin
                    sum = sum + bahs_pkg::SUM_W'(bahs_pkg::popcount8(diff[7:0]));
                end
            end

            // Distance clips at the field's top value
            always_comb begin
                if (sum > bahs_pkg::SUM_W'(bahs_pkg::DIST_MAX)) begin
                    dist_val = bahs_pkg::DIST_MAX;
                end else begin
                    dist_val = bahs_pkg::DIST_W'(sum);
                end
            end

            assign match.distance[s] = dist_val;
            assign match.mask[s]     = (dist_val < cfg.threshold);
        end
    endgenerate

    assign match.pos = position;

endmodule

>>> design/bahs_out.sv
`timescale 1ns / 1ps

module bahs_out (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bahs_pkg::match_t                  match,
    input  logic                              in_valid,
    output logic                              can_take,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bahs_pkg::POS_W-1:0]        m_window_start,
    output logic [bahs_pkg::SHIFT_W-1:0]      m_bit_shift,
    output logic [bahs_pkg::DIST_W-1:0]       m_distance,
    output logic                              m_last
);

    logic [bahs_pkg::NUM_SHIFTS-1:0]              mask_reg, mask_next, mask_rest;
    logic [bahs_pkg::NUM_SHIFTS-1:0][bahs_pkg::DIST_W-1:0] dist_reg;
    logic [bahs_pkg::POS_W-1:0]                   pos_reg;
    logic [bahs_pkg::SHIFT_W-1:0]                 sel;
    logic                                         take, load;

    // Lowest pending alignment goes out first
    always_comb begin
        sel = '0;
        for (int i = bahs_pkg::NUM_SHIFTS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel = bahs_pkg::SHIFT_W'(i);
            end
        end
    end

    assign mask_rest = mask_reg & (mask_reg - bahs_pkg::NUM_SHIFTS'(1));
    assign m_valid   = |mask_reg;
    assign m_last    = (mask_rest == '0);
    assign take      = m_valid && m_ready;
    assign can_take  = !m_valid || (take && m_last);
    assign load      = in_valid && can_take;

    always_comb begin
        mask_next = mask_reg;
        if (load) begin
            mask_next = match.mask;
        end else if (take) begin
            mask_next = mask_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    // Distances and position held for the whole burst
    always_ff @(posedge aclk) begin
        if (load) begin
            dist_reg <= match.distance;
            pos_reg  <= match.pos;
        end
    end

    assign m_window_start = pos_reg;
    assign m_bit_shift    = sel;
    assign m_distance     = dist_reg[sel];

endmodule

>>> design/bit_aligned_pattern_hamming_search.sv
`timescale 1ns / 1ps

// Sliding-window bit-aligned Hamming search. Keystream bytes stream in one
// per beat; once the last ten bytes are in, the window is compared against
// the configured difference pattern at all eight bit alignments and every
// alignment whose bit distance is below match_threshold is reported, lowest
// alignment first, with m_last on the final result of that byte. A byte is
// taken every cycle unless a matching window waits for the result register;
// the byte loads the window register, the correlation works combinationally
// on that register, and the result register loads its matches once free.
// A byte's results hold the result register until the last one leaves, one
// result leaving per cycle while m_ready is high; a following byte whose
// window also matches waits for it, holding the input. Windows with no match
// never wait. Registers sit on an APB port at byte addresses 0x00, 0x08 and
// 0x10; write only when idle.
module bit_aligned_pattern_hamming_search (
    input  logic                              aclk,
    input  logic                              aresetn,
    // keystream input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_stream_byte,
    input  logic                              s_restart,
    // results
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bahs_pkg::POS_W-1:0]        m_window_start,
    output logic [bahs_pkg::SHIFT_W-1:0]      m_bit_shift,
    output logic [bahs_pkg::DIST_W-1:0]       m_distance,
    output logic                              m_last,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bahs_pkg::PADDR_W-1:0]      paddr,
    input  logic [bahs_pkg::PDATA_W-1:0]      pwdata,
    output logic [bahs_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    bahs_pkg::cfg_t              cfg;
    bahs_pkg::match_t            match;
    logic [bahs_pkg::WIN_W-1:0]  window;
    logic [bahs_pkg::POS_W-1:0]  position;
    logic                        win_valid, advance, out_can_take, has_match;

    bahs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bahs_window u_window (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_stream_byte (s_stream_byte),
        .s_restart     (s_restart),
        .advance       (advance),
        .window        (window),
        .position      (position),
        .win_valid     (win_valid)
    );

    bahs_corr u_corr (
        .window   (window),
        .position (position),
        .cfg      (cfg),
        .match    (match)
    );

    // A window with no match retires at once; otherwise it waits for the
    // result register to free up
    assign has_match = |match.mask;
    assign advance   = win_valid && (!has_match || out_can_take);

    bahs_out u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .match          (match),
        .in_valid       (win_valid && has_match),
        .can_take       (out_can_take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_window_start (m_window_start),
        .m_bit_shift    (m_bit_shift),
        .m_distance     (m_distance),
        .m_last         (m_last)
    );

endmodule
